// ===== hdl/pge_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pge_pkg
// Shared types and constants for the pitch glide envelope block.
// ----------------------------------------------------------------------------
package pge_pkg;

  localparam int NUM_OSC_DEF = 32;
  localparam int OSC_W       = 5;
  localparam int PITCH_W     = 32;
  localparam int WEIGHT_W    = 11;
  localparam int CNT_W       = 11;
  localparam int OSC_CMP_W   = 9;   // holds NUM_OSC up to 256

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_GLIDE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_BLEND,
    ST_FIN
  } state_t;

  // Control from the sequencer decode to the datapath
  typedef struct packed {
    logic in_ready;
    logic mul_lo;    // lower table point times (255 - fraction)
    logic mul_hi;    // upper table point times fraction
    logic mul_bl;    // weight times pitch difference
    logic fin;
  } ctrl_t;

  // Nine-point envelope breakpoints
  function automatic logic [WEIGHT_W-1:0] env_point(input logic [3:0] idx);
    logic [WEIGHT_W-1:0] v;
    unique case (idx)
      4'd0:    v = 11'd0;
      4'd1:    v = 11'd32;
      4'd2:    v = 11'd64;
      4'd3:    v = 11'd96;
      4'd4:    v = 11'd256;
      4'd5:    v = 11'd512;
      4'd6:    v = 11'd768;
      4'd7:    v = 11'd1024;
      4'd8:    v = 11'd1024;
      default: v = 11'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/pitch_glide_envelope.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_glide_envelope
// Per-oscillator start/end pitch store with wander and envelope blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command. A load
//   beat writes start and end pitch of one oscillator; a glide beat adds the
//   signed wander to both. Either way one result beat follows on the output
//   channel (out_valid/out_ready): osc_out, the blended frequency and the
//   envelope weight read from the tick counter before end_of_tick advances it.
// Timing:
//   One shared 33x11 multiplier does all the arithmetic, three passes per
//   beat: lower table point, upper table point, weight times pitch difference.
//   A beat runs through the sequencer steps in order: accept, two weight
//   passes, blend pass, finish; the result is registered in the finish step,
//   and the next beat is accepted only once the sequencer is back in accept.
// Reset:
//   rst clears the sequencer, the tick counter and out_valid. Pitch RAMs are
//   not cleared; an oscillator must be loaded before it is glided.
// Stalls:
//   A result waiting in the output register does not block acceptance of the
//   next beat; the sequencer only holds in its finish step while the output
//   register is still full and not being taken.
// ----------------------------------------------------------------------------
module pitch_glide_envelope #(
  parameter int NUM_OSC = pge_pkg::NUM_OSC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic [pge_pkg::OSC_W-1:0]            osc,
  input  logic signed [pge_pkg::PITCH_W-1:0]   start_load,
  input  logic signed [pge_pkg::PITCH_W-1:0]   end_load,
  input  logic signed [12:0]                   start_wander,
  input  logic signed [4:0]                    end_wander,
  input  logic                                 end_of_tick,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [pge_pkg::OSC_W-1:0]            osc_out,
  output logic signed [pge_pkg::PITCH_W-1:0]   frequency,
  output logic [pge_pkg::WEIGHT_W-1:0]         weight
);

  localparam int AW = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
  localparam int OW = pge_pkg::OSC_W;
  localparam int PW = pge_pkg::PITCH_W;
  localparam int WW = pge_pkg::WEIGHT_W;
  localparam int CW = pge_pkg::OSC_CMP_W;

  // Sequencer
  pge_pkg::state_t state, state_next;
  pge_pkg::ctrl_t  ctrl;

  // Captured beat
  logic              item_cmd;
  logic [OW-1:0]     item_osc;
  logic [PW-1:0]     item_start;
  logic [PW-1:0]     item_end;
  logic [12:0]       item_swander;
  logic [4:0]        item_ewander;
  logic              item_eot;
  logic              item_hit;

  // Datapath
  logic [pge_pkg::CNT_W-1:0] tick_count;
  logic [PW-1:0]     start_rd, end_rd;
  logic [PW-1:0]     pitch_s, pitch_e;
  logic [PW-1:0]     start_new, end_new;
  logic [18:0]       acc;
  logic [19:0]       wsum;
  logic [WW-1:0]     m;
  logic signed [44:0] prod;

  logic signed [32:0] mul_a;
  logic [WW-1:0]      mul_b;
  logic signed [44:0] mul_p;

  logic [2:0]        seg;
  logic [7:0]        frac;
  logic [AW+OW-1:0]  osc_in_wide, osc_q_wide;
  logic [AW-1:0]     idx_in, idx_q;
  logic              hit_in;
  logic              accept, fin_go;

  logic [PW-1:0]     start_mem [NUM_OSC];
  logic [PW-1:0]     end_mem   [NUM_OSC];

  assign accept = in_valid && in_ready;
  assign fin_go = ctrl.fin && (!out_valid || out_ready);

  assign osc_in_wide = {{AW{1'b0}}, osc};
  assign osc_q_wide  = {{AW{1'b0}}, item_osc};
  assign idx_in      = osc_in_wide[AW-1:0];
  assign idx_q       = osc_q_wide[AW-1:0];
  assign hit_in      = {{(CW-OW){1'b0}}, osc} < CW'(NUM_OSC);

  assign seg  = tick_count[10:8];
  assign frac = tick_count[7:0];

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      pge_pkg::ST_IDLE:  if (in_valid) state_next = pge_pkg::ST_MUL0;
      pge_pkg::ST_MUL0:  state_next = pge_pkg::ST_MUL1;
      pge_pkg::ST_MUL1:  state_next = pge_pkg::ST_BLEND;
      pge_pkg::ST_BLEND: state_next = pge_pkg::ST_FIN;
      pge_pkg::ST_FIN:   if (!out_valid || out_ready) state_next = pge_pkg::ST_IDLE;
      default:           state_next = pge_pkg::ST_IDLE;
    endcase
  end

  // ---- sequencer outputs ----
  always_comb begin
    ctrl = '0;
    unique case (state)
      pge_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
      pge_pkg::ST_MUL0:  ctrl.mul_lo   = 1'b1;
      pge_pkg::ST_MUL1:  ctrl.mul_hi   = 1'b1;
      pge_pkg::ST_BLEND: ctrl.mul_bl   = 1'b1;
      pge_pkg::ST_FIN:   ctrl.fin      = 1'b1;
      default:           ctrl = '0;
    endcase
  end

  assign in_ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- shared multiplier ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctrl.mul_lo) begin
      mul_a = $signed({22'b0, pge_pkg::env_point({1'b0, seg})});
      mul_b = {3'b0, ~frac};                       // 255 - fraction
    end else if (ctrl.mul_hi) begin
      mul_a = $signed({22'b0, pge_pkg::env_point(4'({1'b0, seg}) + 4'd1)});
      mul_b = {3'b0, frac};
    end else if (ctrl.mul_bl) begin
      mul_a = $signed({pitch_e[PW-1], pitch_e}) - $signed({pitch_s[PW-1], pitch_s});
      mul_b = m;
    end
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});
  assign wsum  = {1'b0, acc} + {1'b0, mul_p[18:0]};

  // New pitch values for the addressed oscillator
  always_comb begin
    if (item_cmd == pge_pkg::CMD_LOAD) begin
      start_new = item_start;
      end_new   = item_end;
    end else begin
      start_new = start_rd + {{(PW-13){item_swander[12]}}, item_swander};
      end_new   = end_rd   + {{(PW-5){item_ewander[4]}}, item_ewander};
    end
  end

  // ---- pitch RAMs ----
  always_ff @(posedge clk) begin
    if (ctrl.mul_hi && item_hit) begin
      start_mem[idx_q] <= start_new;
      end_mem[idx_q]   <= end_new;
    end
    if (accept && hit_in) begin
      start_rd <= start_mem[idx_in];
      end_rd   <= end_mem[idx_in];
    end
  end

  // ---- beat capture and datapath registers ----
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd     <= command;
      item_osc     <= osc;
      item_start   <= start_load;
      item_end     <= end_load;
      item_swander <= start_wander;
      item_ewander <= end_wander;
      item_eot     <= end_of_tick;
      item_hit     <= hit_in;
    end
    if (ctrl.mul_lo) begin
      acc <= mul_p[18:0];
    end
    if (ctrl.mul_hi) begin
      m       <= wsum[18:8];
      pitch_s <= item_hit ? start_new : '0;
      pitch_e <= item_hit ? end_new   : '0;
    end
    if (ctrl.mul_bl) begin
      prod <= mul_p;
    end
  end

  // ---- tick counter ----
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (fin_go && item_eot) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      osc_out   <= item_osc;
      frequency <= $signed(pitch_s + prod[41:10]);
      weight    <= m;
    end
  end

endmodule

// ===== hdl/pge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pge_checker
// Port-level checks for the pitch glide envelope, bound to the top level.
// ----------------------------------------------------------------------------
module pge_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pge_pkg::OSC_W-1:0]          osc_out,
  input logic signed [pge_pkg::PITCH_W-1:0] frequency,
  input logic [pge_pkg::WEIGHT_W-1:0]       weight
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frequency) && $stable(weight)
      && $stable(osc_out))
    else $error("result beat changed while stalled");

  // Lower point weighted by 255-f keeps the weight at or below 1020
  a_weight_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight <= 11'd1020)
    else $error("weight above 1020");

  // One beat at a time through the sequencer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted while a beat is in progress");

  // Nothing to deliver after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind pitch_glide_envelope pge_checker u_pge_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .osc_out   (osc_out),
  .frequency (frequency),
  .weight    (weight)
);
